>>> hw/rtl/multi_slot_timeout_timer_top_macros.svh
// assertion macros for the multi-slot timeout timer
`ifndef MULTI_SLOT_TIMEOUT_TIMER_TOP_MACROS_SVH
`define MULTI_SLOT_TIMEOUT_TIMER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// condition holds on every clock edge out of reset
`define MSTT_CHECK(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("timer check failed");

// consequent holds in the same cycle as the antecedent
`define MSTT_CHECK_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer implication failed");

// consequent holds in the cycle after the antecedent
`define MSTT_CHECK_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer next-cycle check failed");

`else

`define MSTT_CHECK(lbl, clk, rst, expr)
`define MSTT_CHECK_IMP(lbl, clk, rst, ante, cons)
`define MSTT_CHECK_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/mstt_pkg.sv
// shared types and constants of the multi-slot timeout timer
`default_nettype none

package mstt_pkg;

  // field widths fixed by the transaction format
  localparam int KIND_BITS  = 2;
  localparam int EV_BITS    = 2;
  localparam int ID_BITS    = 4;
  localparam int DELAY_BITS = 32;

  // default sizing
  localparam int DEF_SLOTS     = 16;
  localparam int DEF_TIME_BITS = 32;

  // expiry results handled per tick at most
  localparam int MAX_RESULTS = 16;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

  // input kinds
  localparam logic [KIND_BITS-1:0] KIND_REG   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_UNREG = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_TICK  = 2'd2;

  // result events
  localparam logic [EV_BITS-1:0] EV_REG   = 2'd0;
  localparam logic [EV_BITS-1:0] EV_UNREG = 2'd1;
  localparam logic [EV_BITS-1:0] EV_EXP   = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                  start;
    logic                  step;
    logic                  clear;
    logic                  unreg;
    logic [ID_BITS-1:0]    slot;
    logic                  op_tick;
    logic                  periodic;
    logic [DELAY_BITS-1:0] delay;
  } mstt_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/mstt_cell.sv
// one timer slot of the chain, with its scan token
`default_nettype none

module mstt_cell #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = mstt_pkg::DEF_TIME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mstt_pkg::mstt_cmd_t  cmd,
  input  wire logic [TIME_BITS-1:0] tick_count,
  input  wire logic                 tok_in,
  output logic                      tok_out,
  output logic                      hit
);
  import mstt_pkg::*;

  localparam int CW = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;

  logic                  used;
  logic                  token;
  logic [TIME_BITS-1:0]  start_q;
  logic [DELAY_BITS-1:0] delay_q;
  logic                  periodic_q;

  logic [TIME_BITS-1:0]  elapsed;
  logic                  expired;
  logic                  cond;
  logic                  act;

  // modular elapsed time against the stored delay
  assign elapsed = tick_count - start_q;
  assign expired = CW'(elapsed) >= CW'(delay_q);

  // free slot for a register scan, due slot for a tick scan
  assign cond    = cmd.op_tick ? (used && expired) : !used;
  assign hit     = token && cond;
  assign act     = cmd.step && hit;
  assign tok_out = token;

  // token shift and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
      used  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        token <= 1'b0;
      end else if (cmd.start || cmd.step) begin
        token <= tok_in;
      end
      if (cmd.unreg && (int'(cmd.slot) == IDX)) begin
        used <= 1'b0;
      end else if (act) begin
        if (!cmd.op_tick) begin
          used <= 1'b1;
        end else if (!periodic_q) begin
          used <= 1'b0;
        end
      end
    end
  end

  // slot contents, written on claim and on periodic rearm
  always_ff @(posedge clk) begin
    if (act) begin
      if (!cmd.op_tick) begin
        start_q    <= tick_count;
        delay_q    <= cmd.delay;
        periodic_q <= cmd.periodic;
      end else if (periodic_q) begin
        start_q <= tick_count;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mstt_ctrl.sv
// sequencer: tick counter, scan control and result register
`default_nettype none

`include "multi_slot_timeout_timer_top_macros.svh"

module mstt_ctrl #(
  parameter int SLOTS     = mstt_pkg::DEF_SLOTS,
  parameter int TIME_BITS = mstt_pkg::DEF_TIME_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mstt_pkg::KIND_BITS-1:0]  kind,
  input  wire logic [mstt_pkg::DELAY_BITS-1:0] delay,
  input  wire logic                            periodic,
  input  wire logic [mstt_pkg::ID_BITS-1:0]    slot,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mstt_pkg::EV_BITS-1:0]         event_res,
  output logic [mstt_pkg::ID_BITS-1:0]         slot_id,
  output logic                                 ok,
  output logic                                 last,
  input  wire logic [SLOTS-1:0]                tok,
  input  wire logic [SLOTS-1:0]                hits,
  output mstt_pkg::mstt_cmd_t                  cmd,
  output logic [TIME_BITS-1:0]                 tick_count
);
  import mstt_pkg::*;

  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]            state, state_next;
  logic [PW-1:0]         pos, pos_next;
  logic [CNT_BITS-1:0]   n, n_next;
  logic                  pend_valid, pend_valid_next;
  logic [ID_BITS-1:0]    pend_id, pend_id_next;
  logic [TIME_BITS-1:0]  tick_next;
  logic                  op_tick, op_tick_next;
  logic [DELAY_BITS-1:0] reg_delay, reg_delay_next;
  logic                  reg_per, reg_per_next;

  logic                  out_free;
  logic                  in_acc;
  logic                  any_hit;
  logic                  at_end;
  logic                  out_ld;
  logic [EV_BITS-1:0]    ld_ev;
  logic [ID_BITS-1:0]    ld_id;
  logic                  ld_ok;
  logic                  ld_last;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign any_hit  = |hits;
  assign at_end   = (pos == PW'(SLOTS - 1));

  // sequencing of one transaction
  always_comb begin
    state_next      = state;
    pos_next        = pos;
    n_next          = n;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    tick_next       = tick_count;
    op_tick_next    = op_tick;
    reg_delay_next  = reg_delay;
    reg_per_next    = reg_per;
    cmd             = '0;
    cmd.op_tick     = op_tick;
    cmd.delay       = reg_delay;
    cmd.periodic    = reg_per;
    cmd.slot        = slot;
    out_ld          = 1'b0;
    ld_ev           = EV_REG;
    ld_id           = '0;
    ld_ok           = 1'b0;
    ld_last         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            KIND_REG: begin
              op_tick_next   = 1'b0;
              reg_delay_next = delay;
              reg_per_next   = periodic;
              pos_next       = '0;
              cmd.start      = 1'b1;
              state_next     = ST_SCAN;
            end
            KIND_UNREG: begin
              cmd.unreg = 1'b1;
              out_ld    = 1'b1;
              ld_ev     = EV_UNREG;
              ld_id     = slot;
              ld_last   = 1'b1;
            end
            KIND_TICK: begin
              tick_next       = tick_count + TIME_BITS'(1);
              op_tick_next    = 1'b1;
              pos_next        = '0;
              n_next          = '0;
              pend_valid_next = 1'b0;
              cmd.start       = 1'b1;
              state_next      = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          cmd.step = 1'b1;
          pos_next = pos + PW'(1);
          if (!op_tick) begin
            // register: first free slot, or table full at the end
            if (any_hit) begin
              out_ld     = 1'b1;
              ld_id      = ID_BITS'(pos);
              ld_ok      = 1'b1;
              ld_last    = 1'b1;
              cmd.clear  = 1'b1;
              state_next = ST_IDLE;
            end else if (at_end) begin
              out_ld     = 1'b1;
              ld_last    = 1'b1;
              cmd.clear  = 1'b1;
              state_next = ST_IDLE;
            end
          end else begin
            // tick: hold one expiry back so the final one can be marked last
            if (any_hit) begin
              if (pend_valid) begin
                out_ld = 1'b1;
                ld_ev  = EV_EXP;
                ld_id  = pend_id;
              end
              pend_valid_next = 1'b1;
              pend_id_next    = ID_BITS'(pos);
              n_next          = n + CNT_BITS'(1);
              if ((n_next == CNT_BITS'(MAX_RESULTS)) || at_end) begin
                cmd.clear  = 1'b1;
                state_next = ST_FLUSH;
              end
            end else if (at_end) begin
              cmd.clear  = 1'b1;
              state_next = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (pend_valid) begin
            out_ld  = 1'b1;
            ld_ev   = EV_EXP;
            ld_id   = pend_id;
            ld_last = 1'b1;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
      tick_count <= '0;
      op_tick    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pos        <= pos_next;
      n          <= n_next;
      pend_valid <= pend_valid_next;
      tick_count <= tick_next;
      op_tick    <= op_tick_next;
      if (out_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_id   <= pend_id_next;
    reg_delay <= reg_delay_next;
    reg_per   <= reg_per_next;
    if (out_ld) begin
      event_res <= ld_ev;
      slot_id   <= ld_id;
      ok        <= ld_ok;
      last      <= ld_last;
    end
  end

  `MSTT_CHECK(a_one_token, clk, rst, $onehot0(tok))
  `MSTT_CHECK(a_hit_has_token, clk, rst, (hits & ~tok) == '0)
  `MSTT_CHECK_IMP(a_idle_no_pend, clk, rst, state == ST_IDLE, !pend_valid)
  `MSTT_CHECK(a_count_bound, clk, rst, n <= CNT_BITS'(MAX_RESULTS))
  `MSTT_CHECK_NXT(a_reg_scans, clk, rst, in_acc && (kind == KIND_REG), state == ST_SCAN)

endmodule

`default_nettype wire

>>> hw/rtl/multi_slot_timeout_timer_top.sv
// top level of the multi-slot timeout timer: sequencer and chain of slot cells
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid / in_stall | kind, delay, periodic, slot
//   out     | output    | out_valid/out_stall | event_res, slot_id, ok, last
//
// unregister and unused kinds need no scan; register scans the slots up to the
// first free one (at most SLOTS); tick scans the chain up to its end or up to
// MAX_RESULTS expiries, its token stepping one cell per cycle unless stalled.
// synchronous reset frees every slot and zeroes the tick count at once.
// a result held in the output register stalls the scan until it is taken.
`default_nettype none

module multi_slot_timeout_timer_top #(
  parameter int SLOTS     = mstt_pkg::DEF_SLOTS,
  parameter int TIME_BITS = mstt_pkg::DEF_TIME_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mstt_pkg::KIND_BITS-1:0]  kind,
  input  wire logic [mstt_pkg::DELAY_BITS-1:0] delay,
  input  wire logic                            periodic,
  input  wire logic [mstt_pkg::ID_BITS-1:0]    slot,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mstt_pkg::EV_BITS-1:0]         event_res,
  output logic [mstt_pkg::ID_BITS-1:0]         slot_id,
  output logic                                 ok,
  output logic                                 last
);
  import mstt_pkg::*;

  mstt_cmd_t            cmd;
  logic [TIME_BITS-1:0] tick_count;
  logic [SLOTS-1:0]     tok;
  logic [SLOTS-1:0]     hits;

  // sequencer
  mstt_ctrl #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .delay      (delay),
    .periodic   (periodic),
    .slot       (slot),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .slot_id    (slot_id),
    .ok         (ok),
    .last       (last),
    .tok        (tok),
    .hits       (hits),
    .cmd        (cmd),
    .tick_count (tick_count)
  );

  // chain of slot cells, token enters at slot 0
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = cmd.start;
    end else begin : g_link
      assign tok_in = tok[i-1];
    end
    mstt_cell #(
      .IDX       (i),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .tick_count (tick_count),
      .tok_in     (tok_in),
      .tok_out    (tok[i]),
      .hit        (hits[i])
    );
  end

endmodule

`default_nettype wire
